@@ sv/smad_pkg.sv @@
// ----------------------------------------------------------------------------
// smad_pkg
// Shared widths, constants and types of the sliding mean absolute deviation
// unit.
// ----------------------------------------------------------------------------
package smad_pkg;

   localparam int MAX_WINDOW = 1024;
   localparam int AW         = $clog2(MAX_WINDOW);     // window memory address
   localparam int NW         = AW + 1;                 // window length, fill
   localparam int DATA_W     = 32;
   localparam int POS_W      = 32;
   localparam int SUM_W      = DATA_W + AW;            // running window sum
   localparam int DIFF_W     = DATA_W + NW + 1;        // N*x - S, signed
   localparam int TOT_W      = DIFF_W + AW;            // sum of |N*x - S|
   localparam int DIVR_W     = 2 * AW + 1;             // N*N
   localparam int CNT_W      = $clog2(TOT_W + 1);

   localparam logic [NW-1:0]  WINDOW_RESET = NW'(14);
   localparam logic [NW-1:0]  WINDOW_MIN   = NW'(2);
   localparam logic [NW-1:0]  WINDOW_MAX   = NW'(MAX_WINDOW);
   localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(TOT_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SWEEP,
      ST_DRAIN,
      ST_DIVIDE,
      ST_OUTPUT
   } smad_state_type;

   typedef struct packed {
      logic              done;
      logic [TOT_W-1:0]  quotient;
   } smad_div_stat_type;

endpackage

@@ sv/smad_channels.sv @@
// ----------------------------------------------------------------------------
// smad channels
// Valid/ready channels for sample beats in and deviation beats out.
// ----------------------------------------------------------------------------
interface smad_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [smad_pkg::DATA_W-1:0]  sample;
   logic                                new_series;
   logic                                end_of_series;

   modport source (output valid, output sample, output new_series,
                   output end_of_series, input ready);
   modport sink   (input valid, input sample, input new_series,
                   input end_of_series, output ready);
endinterface

interface smad_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [smad_pkg::DATA_W-1:0]         deviation;
   logic [smad_pkg::POS_W-1:0]          sample_position;
   logic                                series_last;

   modport source (output valid, output deviation, output sample_position,
                   output series_last, input ready);
   modport sink   (input valid, input deviation, input sample_position,
                   input series_last, output ready);
endinterface

@@ sv/smad_ram.sv @@
// ----------------------------------------------------------------------------
// smad_ram
// Generic simple dual-port RAM, one write and one read port, read data
// registered.
// ----------------------------------------------------------------------------
module smad_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      write_en,
   input  logic [$clog2(DEPTH)-1:0]  write_addr,
   input  logic [WIDTH-1:0]          write_data,
   input  logic                      read_en,
   input  logic [$clog2(DEPTH)-1:0]  read_addr,
   output logic [WIDTH-1:0]          read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

@@ sv/smad_divider.sv @@
// ----------------------------------------------------------------------------
// smad_divider
// Restoring divider, one quotient bit per cycle, for sum / (N*N).
// ----------------------------------------------------------------------------
module smad_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [smad_pkg::TOT_W-1:0]     dividend,
   input  logic [smad_pkg::DIVR_W-1:0]    divisor,
   output smad_pkg::smad_div_stat_type    status
);
   import smad_pkg::*;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               done_ff, done_in;
   logic [TOT_W-1:0]   quot_ff, quot_in;
   logic [DIVR_W-1:0]  rem_ff, rem_in;
   logic [DIVR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVR_W:0]    trial;
   logic [DIVR_W:0]    trial_diff;

   // The remainder always stays below the divisor, so it fits DIVR_W bits.
   assign trial      = {rem_ff, quot_ff[TOT_W-1]};
   assign trial_diff = trial - {1'b0, divisor_ff};

   always_comb begin
      count_in   = count_ff;
      done_in    = 1'b0;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         count_in   = DIV_STEPS;
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - CNT_W'(1);
         done_in  = (count_ff == CNT_W'(1));
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in  = trial_diff[DIVR_W-1:0];
            quot_in = {quot_ff[TOT_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DIVR_W-1:0];
            quot_in = {quot_ff[TOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = quot_ff;

endmodule

@@ sv/sliding_mean_absolute_deviation_unit.sv @@
// ----------------------------------------------------------------------------
// sliding_mean_absolute_deviation_unit
// Mean absolute deviation over a sliding window of Q16.16 samples.
//
//   Channel   Direction  Handshake          Beat contents
//   req_bus   in         valid/ready        sample, new_series, end_of_series
//   rsp_bus   out        valid/ready        deviation, sample_position,
//                                           series_last
//   csr       in         csr_write_en       window_length (11 bits)
//
// A sample that does not fill the window passes only through the idle and
// update states. Once the window is full a sample also needs N window memory
// reads through its single read port, a 3-stage multiply/absolute/accumulate
// pipe, and a 54-step bit-serial divider by N*N. Reset is synchronous; no
// memory clear pass is run. A waiting result does not block the next sample;
// only a second result stalls until the first beat is taken.
// ----------------------------------------------------------------------------
module sliding_mean_absolute_deviation_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_en,
   input  logic [smad_pkg::NW-1:0]     csr_write_data,
   smad_req_if.sink                    req_bus,
   smad_rsp_if.source                  rsp_bus
);
   import smad_pkg::*;

   smad_state_type           state_ff, state_in;
   logic [NW-1:0]            window_n_ff, window_n_in;
   logic [AW-1:0]            wp_ff, wp_in;
   logic [NW-1:0]            fill_ff, fill_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [DATA_W-1:0]        sample_ff, sample_in;
   logic [POS_W-1:0]         item_pos_ff, item_pos_in;
   logic                     item_last_ff, item_last_in;
   logic [NW-1:0]            idx_ff, idx_in;
   logic                     v1_ff, v1_in, v2_ff, v3_ff;
   logic signed [DIFF_W-1:0] prod_ff;
   logic [DIFF_W-1:0]        absd_ff;
   logic [TOT_W-1:0]         total_ff;
   logic                     total_clear;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]        rsp_dev_ff, rsp_dev_in;
   logic [POS_W-1:0]         rsp_pos_ff, rsp_pos_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     accept;
   logic [POS_W-1:0]         pos_base;
   logic [NW-1:0]            fill_next;
   logic [NW-1:0]            wp_plus;
   logic signed [SUM_W-1:0]  old_val;
   logic signed [DIFF_W-1:0] diff;
   logic [NW-1:0]            csr_clamped;
   logic [2*NW-1:0]          n_square;
   logic                     div_start;
   smad_div_stat_type        div_stat;

   logic                     ram_we, ram_re;
   logic [AW-1:0]            ram_waddr, ram_raddr;
   logic [DATA_W-1:0]        ram_rdata;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);

   assign pos_base  = req_bus.new_series ? '0 : pos_ff;
   assign wp_plus   = {1'b0, wp_ff} + NW'(1);
   assign fill_next = (fill_ff < window_n_ff) ? fill_ff + NW'(1) : fill_ff;
   assign old_val   = (fill_ff >= window_n_ff)
                      ? {{(SUM_W-DATA_W){ram_rdata[DATA_W-1]}}, ram_rdata} : '0;
   assign n_square  = window_n_ff * window_n_ff;

   always_comb begin
      if (csr_write_data < WINDOW_MIN) begin
         csr_clamped = WINDOW_MIN;
      end else if (csr_write_data > WINDOW_MAX) begin
         csr_clamped = WINDOW_MAX;
      end else begin
         csr_clamped = csr_write_data;
      end
   end

   always_comb begin
      state_in     = state_ff;
      window_n_in  = window_n_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      pos_in       = pos_ff;
      sample_in    = sample_ff;
      item_pos_in  = item_pos_ff;
      item_last_in = item_last_ff;
      idx_in       = idx_ff;
      v1_in        = 1'b0;
      total_clear  = 1'b0;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_dev_in   = rsp_dev_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = wp_ff;
      ram_re       = 1'b0;
      ram_raddr    = idx_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // A new series restarts the window before the sample goes in.
               if (req_bus.new_series) begin
                  wp_in   = '0;
                  fill_in = '0;
                  sum_in  = '0;
               end
               ram_re       = 1'b1;
               ram_raddr    = req_bus.new_series ? '0 : wp_ff;
               sample_in    = req_bus.sample;
               item_last_in = req_bus.end_of_series;
               item_pos_in  = pos_base;
               pos_in       = (pos_base == '1) ? pos_base : pos_base + POS_W'(1);
               state_in     = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // Read data holds the entry that the new sample replaces.
            ram_we  = 1'b1;
            sum_in  = sum_ff - old_val
                      + {{(SUM_W-DATA_W){sample_ff[DATA_W-1]}}, sample_ff};
            wp_in   = (wp_plus == window_n_ff) ? '0 : wp_plus[AW-1:0];
            fill_in = fill_next;
            if (fill_next >= window_n_ff) begin
               idx_in      = '0;
               total_clear = 1'b1;
               state_in    = ST_SWEEP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            ram_re = 1'b1;
            v1_in  = 1'b1;
            idx_in = idx_ff + NW'(1);
            if (idx_ff == window_n_ff - NW'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_dev_in   = (|div_stat.quotient[TOT_W-1:DATA_W])
                              ? '1 : div_stat.quotient[DATA_W-1:0];
               rsp_pos_in   = item_pos_ff;
               rsp_last_in  = item_last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A new window length empties the window; the position keeps counting.
      if (csr_write_en) begin
         window_n_in = csr_clamped;
         wp_in       = '0;
         fill_in     = '0;
         sum_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_n_ff  <= WINDOW_RESET;
         wp_ff        <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         pos_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_n_ff  <= window_n_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         pos_ff       <= pos_in;
         v1_ff        <= v1_in;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff    <= sample_in;
      item_pos_ff  <= item_pos_in;
      item_last_ff <= item_last_in;
      idx_ff       <= idx_in;
      rsp_dev_ff   <= rsp_dev_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Sweep pipe: memory read, N*x, |N*x - S|, accumulate.
   assign diff = prod_ff - {{(DIFF_W-SUM_W){sum_ff[SUM_W-1]}}, sum_ff};

   always_ff @(posedge clock) begin
      prod_ff <= $signed({1'b0, window_n_ff}) * $signed(ram_rdata);
      absd_ff <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      if (total_clear) begin
         total_ff <= '0;
      end else if (v3_ff) begin
         total_ff <= total_ff + {{(TOT_W-DIFF_W){1'b0}}, absd_ff};
      end
   end

   smad_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_WINDOW)
   ) u_window_ram (
      .clock      (clock),
      .write_en   (ram_we),
      .write_addr (ram_waddr),
      .write_data (sample_ff),
      .read_en    (ram_re),
      .read_addr  (ram_raddr),
      .read_data  (ram_rdata)
   );

   smad_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total_ff),
      .divisor  (n_square[DIVR_W-1:0]),
      .status   (div_stat)
   );

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.deviation       = rsp_dev_ff;
   assign rsp_bus.sample_position = rsp_pos_ff;
   assign rsp_bus.series_last     = rsp_last_ff;

   // Checks on the window bookkeeping and the sequencing.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= window_n_ff)
      else $error("fill count exceeds window length");

   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, wp_ff} < window_n_ff)
      else $error("write pointer outside window");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SWEEP |-> idx_ff < window_n_ff)
      else $error("sweep index outside window");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside divide state");

endmodule
